>>> rtl/core/dvv_pkg.sv
// ----------------------------------------------------------------------------
// Dotted version validator package
// Shared item types, character constants and status codes for the
// dotted numeric release validator.
// ----------------------------------------------------------------------------
package dvv_pkg;

  // Default limit on the string length; lengths at or above it are too long.
  localparam int unsigned MaxLenDefault = 64;

  // Characters that the form check looks for.
  localparam logic [7:0] ChZero = 8'h30;  // '0'
  localparam logic [7:0] ChOne  = 8'h31;  // '1'
  localparam logic [7:0] ChNine = 8'h39;  // '9'
  localparam logic [7:0] ChDot  = 8'h2e;  // '.'
  localparam logic [7:0] ChDash = 8'h2d;  // '-'
  localparam logic [7:0] ChR    = 8'h72;  // 'r'
  localparam logic [7:0] ChE    = 8'h65;  // 'e'
  localparam logic [7:0] ChV    = 8'h76;  // 'v'

  // Largest value the base length field can carry.
  localparam logic [5:0] BaseLenMax = 6'd63;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  // Phases of the form checker.
  typedef enum logic [3:0] {
    PH_SEG_START  = 4'd0,
    PH_SEG_ZERO   = 4'd1,
    PH_SEG_DIGITS = 4'd2,
    PH_DASH       = 4'd3,
    PH_R          = 4'd4,
    PH_E          = 4'd5,
    PH_REV_START  = 4'd6,
    PH_REV_DIGITS = 4'd7,
    PH_BAD        = 4'd8
  } phase_e;

  // One input request.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] base_length;
    logic       has_revision;
  } out_item_t;

  // Summary of the string seen so far, passed from the scanner to the top.
  typedef struct packed {
    logic       empty;
    logic       too_long;
    logic       form_ok;
    logic       has_rev;
    logic [5:0] base_len;
  } scan_sum_t;

endpackage

>>> rtl/core/dvv_scan.sv
// ----------------------------------------------------------------------------
// Dotted version scanner
// Holds the form-check phase and the saturating length counters, and
// summarizes the string seen so far.
// ----------------------------------------------------------------------------
module dvv_scan import dvv_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       done_i,
  input  logic [7:0] character_i,
  output scan_sum_t  sum_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_LEN);

  phase_e        phase_q, phase_d;
  logic [CW-1:0] char_count_q, char_count_d;
  logic [CW-1:0] base_count_q, base_count_d;
  logic          is_digit;
  logic          in_base;
  logic [CW+5:0] base_wide;

  // Transition of the form checker for one character.
  function automatic phase_e next_phase(phase_e ph, logic [7:0] c, logic dig);
    phase_e nx;
    nx = PH_BAD;
    case (ph)
      PH_SEG_START: begin
        if (c == ChZero) nx = PH_SEG_ZERO;
        else if (dig)    nx = PH_SEG_DIGITS;
      end
      PH_SEG_ZERO: begin
        if (c == ChDot)       nx = PH_SEG_START;
        else if (c == ChDash) nx = PH_DASH;
      end
      PH_SEG_DIGITS: begin
        if (dig)              nx = PH_SEG_DIGITS;
        else if (c == ChDot)  nx = PH_SEG_START;
        else if (c == ChDash) nx = PH_DASH;
      end
      PH_DASH:       if (c == ChR) nx = PH_R;
      PH_R:          if (c == ChE) nx = PH_E;
      PH_E:          if (c == ChV) nx = PH_REV_START;
      PH_REV_START:  if (c >= ChOne && c <= ChNine) nx = PH_REV_DIGITS;
      PH_REV_DIGITS: if (dig) nx = PH_REV_DIGITS;
      default:       nx = PH_BAD;
    endcase
    return nx;
  endfunction

  assign is_digit = (character_i >= ChZero) && (character_i <= ChNine);
  assign in_base  = (phase_q == PH_SEG_START) || (phase_q == PH_SEG_ZERO) ||
                    (phase_q == PH_SEG_DIGITS);

  // Next state: advance on a character, return to reset on the end request.
  always_comb begin
    phase_d      = phase_q;
    char_count_d = char_count_q;
    base_count_d = base_count_q;
    if (done_i) begin
      phase_d      = PH_SEG_START;
      char_count_d = '0;
      base_count_d = '0;
    end else if (step_i) begin
      phase_d = next_phase(phase_q, character_i, is_digit);
      if (char_count_q != MaxCnt) char_count_d = char_count_q + 1'b1;
      if (in_base && phase_d != PH_DASH && phase_d != PH_BAD &&
          base_count_q != MaxCnt) begin
        base_count_d = base_count_q + 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEG_START;
      char_count_q <= '0;
      base_count_q <= '0;
    end else begin
      phase_q      <= phase_d;
      char_count_q <= char_count_d;
      base_count_q <= base_count_d;
    end
  end

  // Summary of the current string; the base length clips at the field limit.
  assign base_wide = (CW+6)'(base_count_q);

  always_comb begin
    sum_o.empty    = (char_count_q == '0);
    sum_o.too_long = (char_count_q == MaxCnt);
    sum_o.form_ok  = (phase_q == PH_SEG_ZERO) || (phase_q == PH_SEG_DIGITS) ||
                     (phase_q == PH_REV_DIGITS);
    sum_o.has_rev  = (phase_q == PH_REV_DIGITS);
    if (base_wide > (CW+6)'(BaseLenMax)) sum_o.base_len = BaseLenMax;
    else                                 sum_o.base_len = base_wide[5:0];
  end

endmodule

>>> rtl/core/dotted_version_validator.sv
// ----------------------------------------------------------------------------
// Dotted version validator
// Checks a release string of dot-separated decimal segments with an optional
// "-rev" revision suffix, one character per request, and reports a status,
// the base length and a revision flag on the end request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o in_item_i  (in_item_t)
//   out      output     out_valid_o/out_stall_i out_item_o (out_item_t)
//
// One request is taken every cycle unless the input stalls; a result appears in
// the cycle after its end request is taken, from the output register.
// The rate is set by the single phase/counter update per character.
// Reset returns the checker to the start of a segment with zero counts.
// The input stalls only while a result waits in the output register and
// the output side stalls.
module dotted_version_validator import dvv_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_acc;
  logic      end_acc;
  scan_sum_t sum;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // Input handshake.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign end_acc    = in_acc && in_item_i.end_of_text;

  dvv_scan #(
    .MAX_LEN(MAX_LEN)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_acc && !in_item_i.end_of_text),
    .done_i     (end_acc),
    .character_i(in_item_i.character),
    .sum_o      (sum)
  );

  // Status encoding with priority empty, too long, invalid.
  always_comb begin
    res.base_length  = '0;
    res.has_revision = 1'b0;
    if (sum.empty) begin
      res.status = ST_EMPTY;
    end else if (sum.too_long) begin
      res.status = ST_TOO_LONG;
    end else if (sum.form_ok) begin
      res.status       = ST_OK;
      res.base_length  = sum.base_len;
      res.has_revision = sum.has_rev;
    end else begin
      res.status = ST_INVALID;
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (end_acc)           out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, loaded only by an end request.
  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  // An end request always produces a result in the next cycle.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> out_valid_q)
    else $error("end request did not produce a result");

  // The input is only held back by a waiting result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled without a pending result");

  // Results that are not ok carry no length and no revision flag.
  a_not_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != ST_OK) |->
      (out_item_q.base_length == '0 && !out_item_q.has_revision))
    else $error("non-ok result carries length or revision");

  // A character request never creates a result by itself.
  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_item_i.end_of_text && !out_valid_q) |=> !out_valid_q)
    else $error("character request produced a result");
`endif

endmodule

>>> verif/tb_dotted_version_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the dotted version validator
// Streams release strings into the validator one character per request and
// closes each with an end request. Every accepted request also runs through a
// local form checker here, which queues the verdict each string should get.
// Each verdict from the block is compared field by field against that queue.
// Stimulus covers directed forms, strings around the length limit, a long
// output hold-off, and mostly well-formed random releases with some damaged.
// ----------------------------------------------------------------------------
module tb_dotted_version_validator;
  import dvv_pkg::*;

  localparam int unsigned MaxLen     = MaxLenDefault;
  localparam int unsigned ItemTarget = 1200;

  // Ways a well-formed release gets damaged in the random part.
  typedef enum int unsigned {
    MUT_BYTE,
    MUT_DASH,
    MUT_LEAD_ZERO,
    MUT_TRUNCATE,
    MUT_SUFFIX,
    MUT_REV_ZERO,
    MUT_DOT,
    MUT_NOISE
  } mutation_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Shared test state.
  out_item_t   expected_verdicts[$];
  logic [7:0]  text_buf[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  bit          steady = 1'b0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  // Local copy of the form checker state.
  phase_e      scan_phase = PH_SEG_START;
  int unsigned scan_len = 0;
  int unsigned scan_base = 0;

  dotted_version_validator #(
    .MAX_LEN(MaxLen)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #6 clk = ~clk;

  // Next phase of the form check for one character.
  function automatic phase_e advance_phase(phase_e ph, logic [7:0] ch);
    phase_e nxt;
    logic   digit;
    digit = (ch >= ChZero) && (ch <= ChNine);
    nxt = PH_BAD;
    case (ph)
      PH_SEG_START: begin
        if (ch == ChZero) nxt = PH_SEG_ZERO;
        else if (digit) nxt = PH_SEG_DIGITS;
      end
      PH_SEG_ZERO: begin
        if (ch == ChDot) nxt = PH_SEG_START;
        else if (ch == ChDash) nxt = PH_DASH;
      end
      PH_SEG_DIGITS: begin
        if (digit) nxt = PH_SEG_DIGITS;
        else if (ch == ChDot) nxt = PH_SEG_START;
        else if (ch == ChDash) nxt = PH_DASH;
      end
      PH_DASH: begin
        if (ch == ChR) nxt = PH_R;
      end
      PH_R: begin
        if (ch == ChE) nxt = PH_E;
      end
      PH_E: begin
        if (ch == ChV) nxt = PH_REV_START;
      end
      PH_REV_START: begin
        if (ch >= ChOne && ch <= ChNine) nxt = PH_REV_DIGITS;
      end
      PH_REV_DIGITS: begin
        if (digit) nxt = PH_REV_DIGITS;
      end
      default: begin
        nxt = PH_BAD;
      end
    endcase
    return nxt;
  endfunction

  // Update the local checker with one accepted request; an end request
  // queues the verdict and starts a fresh string.
  task automatic scan_release(input in_item_t req);
    out_item_t verdict;
    bit        in_base;
    if (!req.end_of_text) begin
      in_base = (scan_phase == PH_SEG_START) || (scan_phase == PH_SEG_ZERO) ||
                (scan_phase == PH_SEG_DIGITS);
      if (scan_len < MaxLen) scan_len++;
      scan_phase = advance_phase(scan_phase, req.character);
      if (in_base && scan_phase != PH_DASH && scan_phase != PH_BAD && scan_base < MaxLen)
        scan_base++;
    end else begin
      verdict = '0;
      if (scan_len == 0) begin
        verdict.status = ST_EMPTY;
      end else if (scan_len >= MaxLen) begin
        verdict.status = ST_TOO_LONG;
      end else if (scan_phase == PH_SEG_ZERO || scan_phase == PH_SEG_DIGITS ||
                   scan_phase == PH_REV_DIGITS) begin
        verdict.status = ST_OK;
        verdict.base_length = (scan_base > 63) ? BaseLenMax : 6'(scan_base);
        verdict.has_revision = (scan_phase == PH_REV_DIGITS);
      end else begin
        verdict.status = ST_INVALID;
      end
      expected_verdicts.push_back(verdict);
      scan_phase = PH_SEG_START;
      scan_len = 0;
      scan_base = 0;
    end
  endtask

  // Offer one request, hold it until accepted, then maybe leave a gap.
  // Called right after a rising edge.
  task automatic send_request(input logic [7:0] ch, input logic eot);
    in_item_t req;
    req.character = ch;
    req.end_of_text = eot;
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_release(req);
    requests_sent++;
    if (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  // Send the buffered text followed by an end request with a random byte.
  task automatic send_buffer();
    foreach (text_buf[i]) send_request(text_buf[i], 1'b0);
    send_request(8'($urandom_range(255)), 1'b1);
    text_buf.delete();
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_buffer();
  endtask

  // Stop sending and wait until every queued verdict has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_digit(int unsigned lo);
    return ChZero + 8'($urandom_range(9, lo));
  endfunction

  function automatic void push_marker();
    text_buf.push_back(ChDash);
    text_buf.push_back(ChR);
    text_buf.push_back(ChE);
    text_buf.push_back(ChV);
  endfunction

  // Build a well-formed release with random segments and optional suffix.
  function automatic void build_release(bit with_rev);
    int unsigned nseg;
    nseg = $urandom_range(4, 1);
    for (int s = 0; s < nseg; s++) begin
      if (s != 0) text_buf.push_back(ChDot);
      if ($urandom_range(4) == 0) begin
        text_buf.push_back(ChZero);
      end else begin
        text_buf.push_back(rand_digit(1));
        repeat ($urandom_range(3)) text_buf.push_back(rand_digit(0));
      end
    end
    if (with_rev) begin
      push_marker();
      text_buf.push_back(rand_digit(1));
      repeat ($urandom_range(3)) text_buf.push_back(rand_digit(0));
    end
  endfunction

  // Damage the buffered release in one random way.
  function automatic void damage_release(mutation_e kind);
    int unsigned pos;
    pos = $urandom_range(text_buf.size());
    case (kind)
      MUT_BYTE: begin
        if (pos < text_buf.size()) text_buf[pos] = 8'($urandom_range(255));
      end
      MUT_DASH: begin
        text_buf.insert(pos, ChDash);
      end
      MUT_LEAD_ZERO: begin
        text_buf.push_front(ChZero);
      end
      MUT_TRUNCATE: begin
        if (text_buf.size() != 0) void'(text_buf.pop_back());
      end
      MUT_SUFFIX: begin
        push_marker();
        if ($urandom_range(1)) text_buf.push_back(rand_digit(1));
      end
      MUT_REV_ZERO: begin
        push_marker();
        text_buf.push_back(ChZero);
      end
      MUT_DOT: begin
        text_buf.push_back(ChDot);
      end
      default: begin
        text_buf.delete();
        repeat ($urandom_range(8)) text_buf.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  // A digit run of exactly len characters, optionally ending in a suffix.
  task automatic send_long_release(int unsigned len, bit with_rev);
    int unsigned base;
    base = with_rev ? len - 5 : len;
    text_buf.push_back(rand_digit(1));
    while (text_buf.size() < base) text_buf.push_back(rand_digit(0));
    if (with_rev) begin
      push_marker();
      text_buf.push_back(rand_digit(1));
    end
    send_buffer();
  endtask

  // Compare one accepted result with the oldest queued verdict.
  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result: status %0d base_length %0d has_revision %0b",
             got.status, got.base_length, got.has_revision);
      mismatches++;
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.base_length !== want.base_length) begin
      $error("base_length: expected %0d, got %0d", want.base_length, got.base_length);
      mismatches++;
    end
    if (got.has_revision !== want.has_revision) begin
      $error("has_revision: expected %0b, got %0b", want.has_revision, got.has_revision);
      mismatches++;
    end
  endtask

  // Result side: check each accepted result and drive the stall, with an
  // occasional long hold-off counted down here.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_verdict(out_item);
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 37);
    end
  end

  // Extremes of the fields and the named corner cases.
  task automatic test_directed();
    send_string("");
    send_string("0");
    send_string("9.0-rev1");
    send_string("01");
    text_buf.push_back(8'h00);
    send_buffer();
    text_buf.push_back(8'hff);
    send_buffer();
    send_string("1-rev");
  endtask

  // Lengths around the limit, with both sides running without gaps.
  task automatic test_length_limit();
    steady = 1'b1;
    for (int unsigned len = MaxLen - 2; len <= MaxLen + 1; len++)
      send_long_release(len, 1'b0);
    send_long_release(MaxLen - 1, 1'b1);
    send_long_release(MaxLen, 1'b1);
    steady = 1'b0;
  endtask

  // Hold the result side off while requests keep coming, then drain.
  task automatic test_backpressure();
    hold_request = 200;
    repeat (4) begin
      build_release(1'($urandom_range(1)));
      send_buffer();
    end
    wait_drain();
  endtask

  // Mostly well-formed releases, some damaged, some noise or long.
  task automatic test_random();
    int unsigned pick;
    while (requests_sent < ItemTarget) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_long_release($urandom_range(MaxLen + 3, MaxLen - 3), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        build_release(1'($urandom_range(1)));
        if (pick >= 60) damage_release(mutation_e'($urandom_range(6)));
        send_buffer();
      end else begin
        damage_release(MUT_NOISE);
        send_buffer();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_length_limit();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dvv_pkg.sv
rtl/core/dvv_scan.sv
rtl/core/dotted_version_validator.sv
verif/tb_dotted_version_validator.sv
